// File: rtl/tcs_pkg.sv
`timescale 1ns / 1ps
package tcs_pkg;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [15:0] RESET_CELL   = 16'h0220;
  localparam logic [7:0]  RESET_COLOR  = 8'h02;
  localparam logic [15:0] RESET_BLANK  = 16'hFF00;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic CFG_TEXT_COLOR = 1'b0;
  localparam logic CFG_BLANK_CELL = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_READ_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } state_t;

endpackage

// File: rtl/tcs_front.sv
`timescale 1ns / 1ps
module tcs_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_tuser,   // kind
  input  logic [23:0]   in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic          q_full,
  input  logic          clearing,
  output logic          push,
  output tcs_pkg::cmd_t cmd,
  output logic [AW-1:0] addr
);

  logic [7:0] ch;
  logic [4:0] rd_row;
  logic [6:0] rd_col;
  logic       in_range;

  assign ch     = in_tdata[7:0];
  assign rd_row = in_tdata[12:8];
  assign rd_col = in_tdata[19:13];

  assign in_tready = !q_full && !clearing;
  assign push      = in_tvalid && in_tready;

  assign in_range = (32'(rd_row) < 32'(ROWS)) && (32'(rd_col) < 32'(COLUMNS));

  always_comb begin
    cmd.ch = ch;
    addr   = AW'(32'(rd_row) * 32'(COLUMNS) + 32'(rd_col));
    if (in_tuser == tcs_pkg::KIND_READ) begin
      cmd.op = in_range ? tcs_pkg::OP_READ : tcs_pkg::OP_READ_NONE;
    end else if (ch == tcs_pkg::NEWLINE_CODE) begin
      cmd.op = tcs_pkg::OP_NEWLINE;
    end else begin
      cmd.op = tcs_pkg::OP_PUT;
    end
  end

endmodule

// File: rtl/tcs_queue.sv
`timescale 1ns / 1ps
module tcs_queue #(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign full     = count_r == 2'd2;
  assign empty    = count_r == 2'd0;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/tcs_back.sv
`timescale 1ns / 1ps
module tcs_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11,
  parameter int RW      = 5,
  parameter int CW      = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  tcs_pkg::cmd_t q_cmd,
  input  logic [AW-1:0] q_addr,
  output logic          q_pop,
  input  logic [7:0]    text_color,
  input  logic [15:0]   blank_cell,
  output logic          clearing,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata
);

  localparam int TOTAL     = ROWS * COLUMNS;
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  logic [15:0] mem [TOTAL];
  logic [15:0] rd_data_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  tcs_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [AW-1:0] row_base_r, row_base_nxt;
  logic          copy_wr_r, copy_wr_nxt;
  logic [AW-1:0] copy_addr_r, copy_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_cell_r, out_cell_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic [6:0]    out_col_r, out_col_nxt;
  logic          out_scr_r, out_scr_nxt;
  logic          step;

  assign clearing   = state_r == tcs_pkg::ST_CLEAR;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_scr_r, out_col_r, out_row_r, out_cell_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    row_base_nxt  = row_base_r;
    copy_wr_nxt   = 1'b0;
    copy_addr_nxt = copy_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_cell_nxt  = out_cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_scr_nxt   = out_scr_r;
    q_pop         = 1'b0;
    step          = 1'b0;
    mem_raddr     = cnt_r;
    mem_we        = copy_wr_r;
    mem_waddr     = copy_addr_r;
    mem_wdata     = rd_data_r;
    case (state_r)
      tcs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = tcs_pkg::RESET_CELL;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == AW'(TOTAL - 1)) begin
          state_nxt = tcs_pkg::ST_IDLE;
        end
      end
      tcs_pkg::ST_IDLE: begin
        if (!q_empty && (!out_valid_r || out_tready)) begin
          q_pop        = 1'b1;
          out_cell_nxt = 16'h0000;
          out_scr_nxt  = 1'b0;
          out_row_nxt  = 5'(cur_row_r);
          out_col_nxt  = 7'(cur_col_r);
          case (q_cmd.op)
            tcs_pkg::OP_READ: begin
              mem_raddr = q_addr;
              state_nxt = tcs_pkg::ST_READ;
            end
            tcs_pkg::OP_READ_NONE: begin
              out_valid_nxt = 1'b1;
            end
            tcs_pkg::OP_PUT, tcs_pkg::OP_NEWLINE: begin
              if (q_cmd.op == tcs_pkg::OP_PUT) begin
                mem_we    = 1'b1;
                mem_waddr = row_base_r + AW'(cur_col_r);
                mem_wdata = {text_color, q_cmd.ch};
              end
              step = (q_cmd.op == tcs_pkg::OP_NEWLINE) ||
                     (cur_col_r == CW'(COLUMNS - 1));
              if (!step) begin
                cur_col_nxt   = cur_col_r + CW'(1);
                out_col_nxt   = 7'(cur_col_r + CW'(1));
                out_valid_nxt = 1'b1;
              end else begin
                cur_col_nxt = '0;
                out_col_nxt = 7'd0;
                if (cur_row_r == RW'(ROWS - 1)) begin
                  out_scr_nxt = 1'b1;
                  cnt_nxt     = AW'(COLUMNS);
                  state_nxt   = tcs_pkg::ST_COPY;
                end else begin
                  cur_row_nxt   = cur_row_r + RW'(1);
                  row_base_nxt  = row_base_r + AW'(COLUMNS);
                  out_row_nxt   = 5'(cur_row_r + RW'(1));
                  out_valid_nxt = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      tcs_pkg::ST_READ: begin
        out_cell_nxt  = rd_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = tcs_pkg::ST_IDLE;
      end
      tcs_pkg::ST_COPY: begin
        // read one row below, write back in the following cycle
        mem_raddr     = cnt_r;
        copy_wr_nxt   = 1'b1;
        copy_addr_nxt = cnt_r - AW'(COLUMNS);
        cnt_nxt       = cnt_r + AW'(1);
        if (cnt_r == AW'(TOTAL - 1)) begin
          cnt_nxt   = AW'(LAST_BASE);
          state_nxt = tcs_pkg::ST_FILL;
        end
      end
      tcs_pkg::ST_FILL: begin
        if (!copy_wr_r) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r;
          mem_wdata = blank_cell;
          cnt_nxt   = cnt_r + AW'(1);
          if (cnt_r == AW'(TOTAL - 1)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = tcs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcs_pkg::ST_CLEAR;
      cnt_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      row_base_r  <= '0;
      copy_wr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      row_base_r  <= row_base_nxt;
      copy_wr_r   <= copy_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_addr_r <= copy_addr_nxt;
    out_cell_r  <= out_cell_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_scr_r   <= out_scr_nxt;
  end

endmodule

// File: rtl/text_terminal_cursor_scroll_unit.sv
`timescale 1ns / 1ps
// Character cell terminal with a ROWS x COLUMNS screen of 16-bit cells.
// Input channel in_*: kind in in_tuser (0 put, 1 read), the rest in in_tdata.
// A put writes {text_color, char} at the cursor and advances it; a newline
// code moves to column 0 of the next row. One result per item on out_*,
// carrying the read cell (0 for puts), the cursor after the item and a
// scroll flag.
// Items pass a two-entry queue from the classifier to the executor.
// A put or newline without scroll, or an off-screen read, passes the queue
// and the output register; an on-screen read also passes the registered read
// port of the screen memory. A steady stream of puts runs at one item per
// cycle while out_tready stays high and no scroll occurs.
// A scroll moves rows 1 to ROWS-1 up by one row, one cell per cycle through
// the single memory port pair, then fills the last row with blank_cell; no
// item executes meanwhile. Reset: the cursor goes home, text_color = 0x02,
// blank_cell = 0xFF00, and a clearing pass writes 0x0220 to every cell with
// in_tready low throughout. Configuration writes are taken at any time.
// A stalled out_tready holds the result; the queue then takes up to two
// further items before in_tready drops.
module text_terminal_cursor_scroll_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // kind
  input  logic [23:0] in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cell_data[15:0], cursor_row[20:16],
                                  // cursor_col[27:21], scrolled[28]
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(ROWS * COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int CMDW = $bits(tcs_pkg::cmd_t);
  localparam int QW = AW + CMDW;

  logic [7:0]  text_color_r, text_color_nxt;
  logic [15:0] blank_cell_r, blank_cell_nxt;

  logic          push, pop, q_full, q_empty, clearing;
  tcs_pkg::cmd_t f_cmd, b_cmd;
  logic [AW-1:0] f_addr, b_addr;
  logic [QW-1:0] q_out;

  always_comb begin
    text_color_nxt = text_color_r;
    blank_cell_nxt = blank_cell_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        tcs_pkg::CFG_TEXT_COLOR: text_color_nxt = cfg_data[7:0];
        tcs_pkg::CFG_BLANK_CELL: blank_cell_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcs_pkg::RESET_COLOR;
      blank_cell_r <= tcs_pkg::RESET_BLANK;
    end else begin
      text_color_r <= text_color_nxt;
      blank_cell_r <= blank_cell_nxt;
    end
  end

  tcs_front #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .cmd       (f_cmd),
    .addr      (f_addr)
  );

  tcs_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_addr, f_cmd}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign b_cmd  = q_out[CMDW-1:0];
  assign b_addr = q_out[QW-1:CMDW];

  tcs_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW), .RW(RW), .CW(CW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (b_cmd),
    .q_addr     (b_addr),
    .q_pop      (pop),
    .text_color (text_color_r),
    .blank_cell (blank_cell_r),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("item accepted during clearing pass");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue popped while empty");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |->
      (out_tdata[20:16] == 5'(ROWS - 1)) && (out_tdata[27:21] == 7'd0))
    else $error("scroll result without cursor at start of last row");

  a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |-> (out_tdata[15:0] == 16'h0000))
    else $error("scroll result carries cell data");

endmodule

// File: tb/text_terminal_cursor_scroll_unit_tb.sv
`timescale 1ns / 1ps
module text_terminal_cursor_scroll_unit_tb;

  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_COLS  = 80;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
  } cell_result_t;

  class terminal_scoreboard;
    logic [15:0]  screen [SCREEN_ROWS*SCREEN_COLS];
    int unsigned  row_pos;
    int unsigned  col_pos;
    logic [7:0]   color;
    logic [15:0]  blank;
    cell_result_t expected_q [$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  scrolls;

    function new();
      foreach (screen[i]) screen[i] = tcs_pkg::RESET_CELL;
      row_pos = 0;
      col_pos = 0;
      color   = tcs_pkg::RESET_COLOR;
      blank   = tcs_pkg::RESET_BLANK;
      errors  = 0;
      checked = 0;
      scrolls = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == tcs_pkg::CFG_TEXT_COLOR) color = value[7:0];
      else blank = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // step to the next row, scrolling the screen up when already at the bottom
    function bit advance_row();
      if (row_pos + 1 < SCREEN_ROWS) begin
        row_pos++;
        return 1'b0;
      end
      for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
        screen[i] = screen[i + SCREEN_COLS];
      for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_ROWS * SCREEN_COLS; i++)
        screen[i] = blank;
      return 1'b1;
    endfunction

    function void note_input(logic kind, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
      tcs_pkg::op_t op;
      cell_result_t res;
      res = '0;
      if (kind == tcs_pkg::KIND_READ)
        op = (rr < SCREEN_ROWS && rc < SCREEN_COLS) ? tcs_pkg::OP_READ : tcs_pkg::OP_READ_NONE;
      else
        op = (ch == tcs_pkg::NEWLINE_CODE) ? tcs_pkg::OP_NEWLINE : tcs_pkg::OP_PUT;
      case (op)
        tcs_pkg::OP_READ: res.cell_word = screen[rr * SCREEN_COLS + rc];
        tcs_pkg::OP_NEWLINE: begin
          res.scrolled = advance_row();
          col_pos = 0;
        end
        tcs_pkg::OP_PUT: begin
          screen[row_pos * SCREEN_COLS + col_pos] = {color, ch};
          col_pos++;
          if (col_pos >= SCREEN_COLS) begin
            col_pos = 0;
            res.scrolled = advance_row();
          end
        end
        default: ;
      endcase
      res.row = row_pos[4:0];
      res.col = col_pos[6:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [31:0] word);
      cell_result_t got;
      cell_result_t exp;
      got.cell_word = word[15:0];
      got.row       = word[20:16];
      got.col       = word[27:21];
      got.scrolled  = word[28];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result %h with nothing pending", word);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.scrolled) scrolls++;
      if (got !== exp) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch #%0d: cell %h/%h row %0d/%0d col %0d/%0d scrolled %0b/%0b (exp/act)",
                   checked, exp.cell_word, got.cell_word, exp.row, got.row, exp.col, got.col,
                   exp.scrolled, got.scrolled);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic        in_tuser   = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en  = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [15:0] cfg_data   = '0;

  terminal_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  bit          hold_req    = 1'b0;

  text_terminal_cursor_scroll_unit #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
      $display("text_terminal_cursor_scroll_unit_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  task automatic send_item(logic kind, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, rc, rr, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(kind, ch, rr, rc);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_colors(logic [7:0] color, logic [15:0] blank);
    cfg_wr_en <= 1'b1;
    cfg_index <= tcs_pkg::CFG_TEXT_COLOR;
    cfg_data  <= {8'($urandom), color};
    @(posedge clk);
    cfg_index <= tcs_pkg::CFG_BLANK_CELL;
    cfg_data  <= blank;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(tcs_pkg::CFG_TEXT_COLOR, {8'h00, color});
    sb.write_reg(tcs_pkg::CFG_BLANK_CELL, blank);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (ch == tcs_pkg::NEWLINE_CODE) ch = 8'h20;
    return ch;
  endfunction

  task automatic put_line(int unsigned len);
    for (int i = 0; i < len; i++)
      send_item(tcs_pkg::KIND_PUT, text_char(), 5'($urandom), 7'($urandom));
    send_item(tcs_pkg::KIND_PUT, tcs_pkg::NEWLINE_CODE, 5'($urandom), 7'($urandom));
  endtask

  task automatic read_cells(int unsigned count);
    logic [4:0] rr;
    logic [6:0] rc;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          rr = 5'($urandom);
          rc = 7'($urandom);
        end
        1: begin
          rr = sb.row_pos[4:0];
          rc = 7'($urandom_range(0, SCREEN_COLS - 1));
        end
        default: begin
          rr = 5'($urandom_range(0, SCREEN_ROWS - 1));
          rc = 7'($urandom_range(0, SCREEN_COLS - 1));
        end
      endcase
      send_item(tcs_pkg::KIND_READ, 8'($urandom), rr, rc);
    end
  endtask

  task automatic run_random(int unsigned count, bit long_first, bit pause_mid);
    int unsigned start;
    int unsigned len;
    bit          paused;
    start  = items_sent;
    paused = 1'b0;
    if (long_first) put_line(SCREEN_COLS);
    while (items_sent - start < count) begin
      if (pause_mid && !paused && items_sent - start >= count / 2) begin
        drain();
        paused = 1'b1;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(76, 85) : $urandom_range(0, 14);
          put_line(len);
        end
        12, 13, 14, 15, 16: read_cells($urandom_range(1, 4));
        default: send_item(1'($urandom_range(0, 1)), 8'($urandom), 5'($urandom),
                           7'($urandom));
      endcase
    end
  endtask

  initial begin
    int unsigned directed;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, field extremes, off-screen reads, scroll by newline
    send_item(tcs_pkg::KIND_PUT, 8'h00, 5'h1F, 7'h7F);
    send_item(tcs_pkg::KIND_PUT, 8'hFF, 5'h00, 7'h00);
    send_item(tcs_pkg::KIND_READ, tcs_pkg::NEWLINE_CODE, 5'd0, 7'd0);
    send_item(tcs_pkg::KIND_READ, 8'hFF, 5'd24, 7'd79);
    send_item(tcs_pkg::KIND_READ, 8'h00, 5'h1F, 7'h7F);
    send_item(tcs_pkg::KIND_READ, 8'h00, 5'd0, 7'd80);
    for (int i = 0; i < SCREEN_ROWS; i++)
      send_item(tcs_pkg::KIND_PUT, tcs_pkg::NEWLINE_CODE, 5'd0, 7'd0);
    send_item(tcs_pkg::KIND_READ, 8'h00, 5'd24, 7'd0);
    directed = items_sent;

    // long receiver hold-off while the sender keeps pushing
    hold_req   = 1'b1;
    burst_left = 60;
    run_random(80, 1'b0, 1'b0);
    drain();
    repeat (4) @(posedge clk);

    set_colors(8'h00, 16'h0000);
    run_random(80, 1'b0, 1'b0);
    drain();
    repeat (4) @(posedge clk);

    set_colors(8'hFF, 16'hFFFF);
    run_random(80, 1'b1, 1'b0);
    drain();
    repeat (4) @(posedge clk);

    set_colors(8'($urandom), 16'($urandom));
    run_random(80, 1'b0, 1'b1);
    drain();
    repeat (4) @(posedge clk);

    set_colors(8'h1F, 16'h0720);
    run_random(80, 1'b1, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    $display("%0d items (%0d directed), %0d results checked, %0d scrolls",
             items_sent, directed, sb.checked, sb.scrolls);
    $display("5 color/blank settings incl. all-zero and all-one, reads on and off screen");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("text_terminal_cursor_scroll_unit_tb: done, clean");
    end else begin
      $display("%0d errors, %0d results missing", sb.errors, sb.pending());
      $display("text_terminal_cursor_scroll_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
